[src/fir_gen_pkg.sv]
// ----------------------------------------------------------------------------
// fir_gen_pkg
// Shared constants, codes and types of the streaming direct-form FIR filter.
// ----------------------------------------------------------------------------
package fir_gen_pkg;

  // Filter size and sample format.
  localparam int MAX_TAPS     = 32;
  localparam int SAMPLE_WIDTH = 16;

  // Field widths that the interface fixes.
  localparam int TAP_SEL_W = 5;   // width of the coefficient index field
  localparam int CFG_W     = 6;   // width of the tap count register
  localparam int IDX_W     = 16;  // width of the result position
  localparam int SUM_W     = 37;  // width of the result sum

  // Derived widths.
  localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
  localparam int FILL_W      = $clog2(MAX_TAPS + 1);
  localparam int PROD_W      = 2 * SAMPLE_WIDTH;
  localparam int TREE_LEVELS = $clog2(MAX_TAPS);
  localparam int TREE_SIZE   = 1 << TREE_LEVELS;

  // Tap count after reset.
  localparam logic [CFG_W-1:0] TAP_COUNT_RESET = CFG_W'(32);

  // Item commands.
  typedef enum logic {
    CMD_COEF   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // Sideband that travels with a result through the pipeline.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic             last;
  } tag_t;

endpackage

[src/fir_gen_state.sv]
// ----------------------------------------------------------------------------
// fir_gen_state
// Tap count register, coefficient store, sample window and block counters.
// ----------------------------------------------------------------------------
module fir_gen_state (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  input  logic [fir_gen_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                     in_accept_i,
  input  logic                                     command_i,
  input  logic [fir_gen_pkg::TAP_SEL_W-1:0]        tap_index_i,
  input  logic signed [fir_gen_pkg::SAMPLE_WIDTH-1:0] coefficient_i,
  input  logic signed [fir_gen_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic                                     last_sample_i,
  input  logic                                     move_i,
  output logic signed [fir_gen_pkg::SAMPLE_WIDTH-1:0] window_o [fir_gen_pkg::MAX_TAPS],
  output logic signed [fir_gen_pkg::SAMPLE_WIDTH-1:0] coef_o [fir_gen_pkg::MAX_TAPS],
  output logic [fir_gen_pkg::FILL_W-1:0]           taps_o,
  output fir_gen_pkg::tag_t                        tag_o
);
  import fir_gen_pkg::*;

  logic [CFG_W-1:0]              tap_count_q;
  logic signed [SAMPLE_WIDTH-1:0] window_q [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] coef_q   [MAX_TAPS];
  logic [FILL_W-1:0]             fill_q, fill_d;
  logic [IDX_W-1:0]              count_q, count_d;
  tag_t                          tag_q, tag_d;
  logic [FILL_W-1:0]             taps;
  logic [FILL_W-1:0]             fill_clamp;
  logic [FILL_W-1:0]             fill_inc;
  logic                          is_sample;
  logic                          produce;

  // Taps in use: zero acts as one, values past the store act as its size.
  always_comb begin
    if (tap_count_q == '0) begin
      taps = FILL_W'(1);
    end else if (32'(tap_count_q) > MAX_TAPS) begin
      taps = FILL_W'(MAX_TAPS);
    end else begin
      taps = FILL_W'(tap_count_q);
    end
  end

  // Fill and result counters for one pushed sample.
  always_comb begin
    is_sample  = in_accept_i && (command_i == CMD_SAMPLE);
    fill_clamp = (fill_q > taps) ? taps : fill_q;
    fill_inc   = (fill_clamp < taps) ? fill_clamp + FILL_W'(1) : fill_clamp;
    produce    = is_sample && (fill_inc >= taps);

    fill_d  = fill_q;
    count_d = count_q;
    if (is_sample) begin
      fill_d = fill_inc;
      if (produce) begin
        count_d = count_q + IDX_W'(1);
      end
      if (last_sample_i) begin
        fill_d  = '0;
        count_d = '0;
      end
    end

    // The tag stays until the product stage takes it.
    tag_d = tag_q;
    if (move_i) begin
      tag_d.valid = 1'b0;
    end
    if (produce) begin
      tag_d.valid = 1'b1;
      tag_d.index = count_q;
      tag_d.last  = last_sample_i;
    end
  end

  // Tap count register; the write channel is always ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= TAP_COUNT_RESET;
    end else if (cfg_valid_i) begin
      tap_count_q <= cfg_data_i;
    end
  end

  // Counters and pending tag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
      tag_q   <= '0;
    end else begin
      fill_q  <= fill_d;
      count_q <= count_d;
      tag_q   <= tag_d;
    end
  end

  // Sample window and coefficient store, both cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        window_q[k] <= '0;
        coef_q[k]   <= '0;
      end
    end else if (in_accept_i) begin
      if (command_i == CMD_SAMPLE) begin
        window_q[0] <= sample_i;
        for (int k = 1; k < MAX_TAPS; k++) begin
          window_q[k] <= window_q[k-1];
        end
      end else begin
        for (int k = 0; k < MAX_TAPS; k++) begin
          if (32'(tap_index_i) == k) begin
            coef_q[k] <= coefficient_i;
          end
        end
      end
    end
  end

  assign window_o = window_q;
  assign coef_o   = coef_q;
  assign taps_o   = taps;
  assign tag_o    = tag_q;

endmodule

[src/fir_gen_mult.sv]
// ----------------------------------------------------------------------------
// fir_gen_mult
// Product stage: one multiplier per tap, fed from the window and the store.
// ----------------------------------------------------------------------------
module fir_gen_mult (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic signed [fir_gen_pkg::SAMPLE_WIDTH-1:0] window_i [fir_gen_pkg::MAX_TAPS],
  input  logic signed [fir_gen_pkg::SAMPLE_WIDTH-1:0] coef_i [fir_gen_pkg::MAX_TAPS],
  input  logic [fir_gen_pkg::FILL_W-1:0]              taps_i,
  input  fir_gen_pkg::tag_t                           tag_i,
  input  logic                                        ready_i,
  output logic                                        move_o,
  output logic signed [fir_gen_pkg::PROD_W-1:0]       prod_o [fir_gen_pkg::MAX_TAPS],
  output fir_gen_pkg::tag_t                           tag_o
);
  import fir_gen_pkg::*;

  logic signed [PROD_W-1:0] prod_q [MAX_TAPS];
  logic signed [PROD_W-1:0] prod_d [MAX_TAPS];
  logic [FILL_W-1:0]        sel    [MAX_TAPS];
  tag_t                     tag_q;
  logic                     load;

  // Tap k pairs coefficient k with the sample pushed taps-1-k steps ago.
  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      sel[k] = taps_i - FILL_W'(1) - FILL_W'(k);
      if (FILL_W'(k) < taps_i) begin
        prod_d[k] = coef_i[k] * window_i[sel[k][TAP_IDX_W-1:0]];
      end else begin
        prod_d[k] = '0;
      end
    end
  end

  // The stage loads when empty or when its content moves on.
  assign load   = !tag_q.valid || ready_i;
  assign move_o = tag_i.valid && load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (load) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && tag_i.valid) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;
  assign tag_o  = tag_q;

endmodule

[src/fir_gen_tree.sv]
// ----------------------------------------------------------------------------
// fir_gen_tree
// Registered pairwise adder tree; its last level is the output register.
// ----------------------------------------------------------------------------
module fir_gen_tree (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [fir_gen_pkg::PROD_W-1:0] prod_i [fir_gen_pkg::MAX_TAPS],
  input  fir_gen_pkg::tag_t                     tag_i,
  output logic                                  ready_o,
  input  logic                                  out_stall_i,
  output logic                                  out_valid_o,
  output logic signed [fir_gen_pkg::SUM_W-1:0]  filter_sum_o,
  output logic [fir_gen_pkg::IDX_W-1:0]         output_index_o,
  output logic                                  last_result_o
);
  import fir_gen_pkg::*;

  localparam int HALF = TREE_SIZE / 2;

  logic signed [SUM_W-1:0] leaf  [TREE_SIZE];
  logic signed [SUM_W-1:0] lvl_q [TREE_LEVELS][HALF];
  tag_t                    tag_q [TREE_LEVELS];
  logic                    rdy   [TREE_LEVELS+1];

  // Leaves: products sign-extended to the sum width, padding reads zero.
  always_comb begin
    for (int i = 0; i < TREE_SIZE; i++) begin
      if (i < MAX_TAPS) begin
        leaf[i] = SUM_W'(prod_i[i]);
      end else begin
        leaf[i] = '0;
      end
    end
  end

  // Each level loads when empty or when the level after it takes its data.
  always_comb begin
    rdy[TREE_LEVELS] = !out_stall_i;
    for (int l = TREE_LEVELS - 1; l >= 0; l--) begin
      rdy[l] = !tag_q[l].valid || rdy[l+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < TREE_LEVELS; l++) begin
        tag_q[l] <= '0;
      end
    end else begin
      for (int l = 0; l < TREE_LEVELS; l++) begin
        if (rdy[l]) begin
          tag_q[l] <= (l == 0) ? tag_i : tag_q[l-1];
        end
      end
    end
  end

  // Sums wrap at the result width.
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < TREE_LEVELS; l++) begin
      if (rdy[l]) begin
        for (int i = 0; i < HALF; i++) begin
          if (i >= (TREE_SIZE >> (l + 1))) begin
            lvl_q[l][i] <= '0;
          end else if (l == 0) begin
            lvl_q[l][i] <= leaf[2*i] + leaf[2*i+1];
          end else begin
            lvl_q[l][i] <= lvl_q[l-1][2*i] + lvl_q[l-1][2*i+1];
          end
        end
      end
    end
  end

  assign ready_o        = rdy[0];
  assign out_valid_o    = tag_q[TREE_LEVELS-1].valid;
  assign filter_sum_o   = lvl_q[TREE_LEVELS-1][0];
  assign output_index_o = tag_q[TREE_LEVELS-1].index;
  assign last_result_o  = tag_q[TREE_LEVELS-1].last;

endmodule

[src/fir_filter_generic_top.sv]
// ----------------------------------------------------------------------------
// fir_filter_generic_top
// Streaming direct-form FIR filter with exact fixed-point sums.
// ----------------------------------------------------------------------------
// The block takes one request per clock while in_stall_o is low. A
// coefficient request writes one entry of the store; a sample request shifts
// the window and, once the block holds tap_count samples, yields the exact sum
// of coefficient k times the sample pushed tap_count-1-k steps earlier. A
// result passes through the pending tag of the state block, the register of
// the per-tap multipliers and one register per level of the adder tree. Each
// stage holds its data while the next one is full, so a stalled result does
// not stop new requests until the pipeline has no empty stage left. The tap
// count register has its own write channel, which is always ready.
// ----------------------------------------------------------------------------
module fir_filter_generic_top (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // Configuration write channel.
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [fir_gen_pkg::CFG_W-1:0]               cfg_data_i,
  // Input channel.
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  logic                                        command_i,
  input  logic [fir_gen_pkg::TAP_SEL_W-1:0]           tap_index_i,
  input  logic signed [fir_gen_pkg::SAMPLE_WIDTH-1:0] coefficient_i,
  input  logic signed [fir_gen_pkg::SAMPLE_WIDTH-1:0] sample_i,
  input  logic                                        last_sample_i,
  // Output channel.
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output logic signed [fir_gen_pkg::SUM_W-1:0]        filter_sum_o,
  output logic [fir_gen_pkg::IDX_W-1:0]               output_index_o,
  output logic                                        last_result_o
);
  import fir_gen_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] window [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] coef   [MAX_TAPS];
  logic signed [PROD_W-1:0]       prod   [MAX_TAPS];
  logic [FILL_W-1:0]              taps;
  tag_t                           tag_state;
  tag_t                           tag_mult;
  logic                           move;
  logic                           tree_ready;
  logic                           in_accept;

  // A pending result must reach the multipliers before the state changes.
  assign in_stall_o  = tag_state.valid && !move;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  fir_gen_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .in_accept_i   (in_accept),
    .command_i     (command_i),
    .tap_index_i   (tap_index_i),
    .coefficient_i (coefficient_i),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .move_i        (move),
    .window_o      (window),
    .coef_o        (coef),
    .taps_o        (taps),
    .tag_o         (tag_state)
  );

  fir_gen_mult u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .window_i (window),
    .coef_i   (coef),
    .taps_i   (taps),
    .tag_i    (tag_state),
    .ready_i  (tree_ready),
    .move_o   (move),
    .prod_o   (prod),
    .tag_o    (tag_mult)
  );

  fir_gen_tree u_tree (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .prod_i         (prod),
    .tag_i          (tag_mult),
    .ready_o        (tree_ready),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .filter_sum_o   (filter_sum_o),
    .output_index_o (output_index_o),
    .last_result_o  (last_result_o)
  );

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the streaming direct-form FIR filter.
// ----------------------------------------------------------------------------
// Coefficient and sample requests go in through the stall handshake. A
// predictor in the testbench keeps its own window, coefficient store, fill
// level and result position, and it queues the exact sum that each accepted
// sample should produce. The result monitor compares every accepted result,
// field by field, with the oldest queued sum.
//
// Directed tests cover full-scale sums, the tap count extremes, short blocks,
// coefficient writes inside a block and tap count changes inside a block.
// Random traffic then runs over many tap counts. A back-pressure test follows.
// Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import fir_gen_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned IDLE_PCT     = 37;

  // One request on the input channel.
  typedef struct {
    cmd_e                           cmd;
    logic [TAP_SEL_W-1:0]           tap_sel;
    logic signed [SAMPLE_WIDTH-1:0] coef;
    logic signed [SAMPLE_WIDTH-1:0] smp;
    logic                           last;
  } fir_req_t;

  // One filter output.
  typedef struct {
    logic signed [SUM_W-1:0] sum;
    logic [IDX_W-1:0]        index;
    logic                    last;
  } fir_sum_t;

  // Ports of the block.
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [CFG_W-1:0]               cfg_data_i    = '0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic                           command_i     = 1'b0;
  logic [TAP_SEL_W-1:0]           tap_index_i   = '0;
  logic signed [SAMPLE_WIDTH-1:0] coefficient_i = '0;
  logic signed [SAMPLE_WIDTH-1:0] sample_i      = '0;
  logic                           last_sample_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic signed [SUM_W-1:0]        filter_sum_o;
  logic [IDX_W-1:0]               output_index_o;
  logic                           last_result_o;

  // Predictor state.
  logic signed [SAMPLE_WIDTH-1:0] window_q [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] coef_q [MAX_TAPS];
  int unsigned                    fill_level;
  logic [IDX_W-1:0]               result_pos;
  logic [CFG_W-1:0]               tap_reg;
  fir_sum_t                       pending_sums[$];

  int unsigned error_count = 0;
  bit          idle_en     = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;

  fir_filter_generic_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .tap_index_i   (tap_index_i),
    .coefficient_i (coefficient_i),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .filter_sum_o  (filter_sum_o),
    .output_index_o(output_index_o),
    .last_result_o (last_result_o)
  );

  // Clock.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: ends the run if it takes far longer than any correct run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Taps in use: zero acts as one, anything above the maximum as the maximum.
  function automatic int unsigned taps_in_use();
    if (tap_reg == 0) return 1;
    if (tap_reg > MAX_TAPS) return MAX_TAPS;
    return tap_reg;
  endfunction

  // Updates the predictor with one accepted request and queues its sum.
  function automatic void predict_fir(input fir_req_t req);
    int unsigned t;
    longint      acc;
    fir_sum_t    res;
    t = taps_in_use();
    if (req.cmd == CMD_COEF) begin
      coef_q[req.tap_sel] = req.coef;
      return;
    end
    for (int k = MAX_TAPS - 1; k > 0; k--) window_q[k] = window_q[k-1];
    window_q[0] = req.smp;
    if (fill_level > t) fill_level = t;
    if (fill_level < t) fill_level++;
    if (fill_level >= t) begin
      acc = 0;
      for (int unsigned k = 0; k < t; k++) begin
        acc += longint'(coef_q[k]) * longint'(window_q[t-1-k]);
      end
      res.sum   = acc[SUM_W-1:0];
      res.index = result_pos;
      res.last  = req.last;
      pending_sums.push_back(res);
      result_pos++;
    end
    // The block ends on its last sample, with or without a result.
    if (req.last) begin
      fill_level = 0;
      result_pos = '0;
    end
  endfunction

  // Random value with a bias toward the extremes.
  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_value();
    case ($urandom_range(19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // Sends one request and updates the predictor once it is accepted.
  task automatic send_req(input fir_req_t req);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= req.cmd;
    tap_index_i   <= req.tap_sel;
    coefficient_i <= req.coef;
    sample_i      <= req.smp;
    last_sample_i <= req.last;
    do @(posedge clk_i); while (in_stall_o);
    predict_fir(req);
  endtask

  // Coefficient write; the unused sample field carries noise.
  task automatic write_coef(input logic [TAP_SEL_W-1:0] sel,
                            input logic signed [SAMPLE_WIDTH-1:0] val,
                            input logic last);
    fir_req_t req;
    req.cmd     = CMD_COEF;
    req.tap_sel = sel;
    req.coef    = val;
    req.smp     = SAMPLE_WIDTH'($urandom);
    req.last    = last;
    send_req(req);
  endtask

  // Sample push; the unused coefficient fields carry noise.
  task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] val,
                             input logic last);
    fir_req_t req;
    req.cmd     = CMD_SAMPLE;
    req.tap_sel = TAP_SEL_W'($urandom);
    req.coef    = SAMPLE_WIDTH'($urandom);
    req.smp     = val;
    req.last    = last;
    send_req(req);
  endtask

  // Waits until every queued sum has arrived and the pipeline is empty.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes the tap count register while the block is idle.
  task automatic set_taps(input logic [CFG_W-1:0] val);
    drain_pipeline();
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tap_reg = val;
  endtask

  // Result monitor and receiver stall.
  always @(posedge clk_i) begin : result_monitor
    fir_sum_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result: filter_sum %0d output_index %0d last_result %0b",
               filter_sum_o, output_index_o, last_result_o);
        error_count++;
      end else begin
        exp_res = pending_sums.pop_front();
        if (filter_sum_o !== exp_res.sum) begin
          $error("filter_sum: expected %0d, actual %0d", exp_res.sum, filter_sum_o);
          error_count++;
        end
        if (output_index_o !== exp_res.index) begin
          $error("output_index: expected %0d, actual %0d", exp_res.index, output_index_o);
          error_count++;
        end
        if (last_result_o !== exp_res.last) begin
          $error("last_result: expected %0b, actual %0b", exp_res.last, last_result_o);
          error_count++;
        end
      end
    end
    // A requested hold-off wins over random stalls.
    if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Reset tap count and full-scale sums of both signs over all 32 taps.
  task automatic test_full_scale();
    for (int i = 0; i < MAX_TAPS; i++) begin
      write_coef(TAP_SEL_W'(i), 16'h8000, i == MAX_TAPS - 1);
    end
    for (int i = 0; i < MAX_TAPS; i++) push_sample(16'h8000, i == MAX_TAPS - 1);
    for (int i = 0; i <= MAX_TAPS; i++) push_sample(16'h7FFF, i == MAX_TAPS);
  endtask

  // Tap counts of zero and above the maximum.
  task automatic test_tap_extremes();
    set_taps(0);
    write_coef(0, 16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7FFF, 1'b1);
    set_taps(63);
    push_sample(16'h1234, 1'b0);
    push_sample(16'hEDCB, 1'b1);
    set_taps(33);
    push_sample(16'h5555, 1'b1);
  endtask

  // A block that ends before it has enough samples makes no result.
  task automatic test_short_block();
    set_taps(4);
    for (int i = 0; i < 4; i++) write_coef(TAP_SEL_W'(i), 16'(i + 1), 1'b0);
    for (int i = 0; i < 3; i++) push_sample(16'(100 * i - 7), i == 2);
    for (int i = 0; i < 5; i++) push_sample(16'(-300 * i + 11), i == 4);
  endtask

  // A coefficient write inside a block ignores its last flag.
  task automatic test_coef_during_block();
    push_sample(16'h0101, 1'b0);
    push_sample(16'hF0F0, 1'b0);
    write_coef(2, 16'h8000, 1'b1);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0003, 1'b1);
  endtask

  // Lowering the tap count inside a block clamps the fill level.
  task automatic test_tap_change_mid_block();
    set_taps(8);
    for (int i = 0; i < 6; i++) push_sample(rand_value(), 1'b0);
    set_taps(3);
    push_sample(rand_value(), 1'b0);
    set_taps(5);
    push_sample(rand_value(), 1'b0);
    push_sample(rand_value(), 1'b1);
  endtask

  // Mostly complete blocks with random content, plus stray writes,
  // short blocks and blocks that run on without a last flag.
  task automatic run_random_blocks(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned t;
    int unsigned nwr;
    sent = 0;
    while (sent < n_items) begin
      t = taps_in_use();
      if ($urandom_range(99) < 8) begin
        write_coef(TAP_SEL_W'($urandom), rand_value(), 1'($urandom_range(1)));
        sent++;
      end else begin
        nwr = $urandom_range(3);
        repeat (nwr) begin
          write_coef(TAP_SEL_W'($urandom_range(t - 1)), rand_value(),
                     1'($urandom_range(1)));
        end
        len = ($urandom_range(99) < 80) ? t + $urandom_range(10) : $urandom_range(1, t);
        for (int unsigned j = 1; j <= len; j++) begin
          push_sample(rand_value(), (j == len) && ($urandom_range(99) >= 5));
        end
        sent += nwr + len;
      end
    end
  endtask

  // Random traffic over a range of tap counts, one phase without idling.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] tap_plan [16];
    tap_plan = '{1, 2, 3, 4, 5, 7, 8, 13, 16, 24, 31, 32, 0, 63, 33, 6};
    tap_plan[15] = CFG_W'($urandom);
    for (int p = 0; p < 16; p++) begin
      set_taps(tap_plan[p]);
      idle_en = (p != 5);
      run_random_blocks(80);
    end
    idle_en = 1'b1;
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_backpressure();
    set_taps(4);
    hold_cycles = 300;
    run_random_blocks(120);
  endtask

  // Test sequence.
  initial begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      window_q[k] = '0;
      coef_q[k]   = '0;
    end
    fill_level = 0;
    result_pos = '0;
    tap_reg    = TAP_COUNT_RESET;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_scale();
    test_tap_extremes();
    test_short_block();
    test_coef_during_block();
    test_tap_change_mid_block();
    test_random_traffic();
    test_backpressure();
    drain_pipeline();

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/fir_gen_pkg.sv
src/fir_gen_state.sv
src/fir_gen_mult.sv
src/fir_gen_tree.sv
src/fir_filter_generic_top.sv
dv/tb.sv
